// ===== sv/pngu_pkg.sv =====
// ----------------------------------------------------------------------------
// pngu_pkg
// Shared types and constants of the PNG scanline unfilter.
// ----------------------------------------------------------------------------
`default_nettype none

package pngu_pkg;

    localparam int MAX_ROW_BYTES_DEF = 2048;
    localparam int MAX_BPP_DEF       = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int ROW_LEN_W  = 12;
    localparam int BPP_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd1;

    // history tap index, wide enough for bytes_per_pixel up to 8
    localparam int HIST_IDX_W = 3;

    // decoupling queue depth
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int QCNT_W   = 2;

    typedef enum logic [2:0] {
        FLT_NONE    = 3'd0,
        FLT_SUB     = 3'd1,
        FLT_UP      = 3'd2,
        FLT_AVERAGE = 3'd3,
        FLT_PAETH   = 3'd4
    } t_filter;

    localparam logic [7:0] FLT_MAX_CODE = 8'd4;

    // one classified byte handed from front to back
    typedef struct packed {
        logic [7:0]            data;
        logic                  err;
        logic                  last;
        logic                  first_row;
        logic                  use_left;
        logic [HIST_IDX_W-1:0] hist_idx;
        t_filter               filter;
    } t_task;

endpackage

`default_nettype wire

// ===== sv/pngu_if.sv =====
// ----------------------------------------------------------------------------
// pngu_if
// Valid/ready channel interfaces: stream bytes in, pixel bytes out, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface pngu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       frame_start;

    modport source (output valid, output stream_byte, output frame_start, input ready);
    modport sink   (input valid, input stream_byte, input frame_start, output ready);
endinterface

interface pngu_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic       row_last;
    logic       bad_filter;

    modport source (output valid, output pixel_byte, output row_last, output bad_filter,
                    input ready);
    modport sink   (input valid, input pixel_byte, input row_last, input bad_filter,
                    output ready);
endinterface

interface pngu_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pngu_pkg::CFG_IDX_W-1:0]   index;
    logic [pngu_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/pngu_ram.sv =====
// ----------------------------------------------------------------------------
// pngu_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pngu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/pngu_front.sv =====
// ----------------------------------------------------------------------------
// pngu_front
// Accepts stream bytes, tracks row position and filter, classifies bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module pngu_front #(
    parameter int MAX_ROW_BYTES = pngu_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_BPP       = pngu_pkg::MAX_BPP_DEF,
    localparam int COL_W        = $clog2(MAX_ROW_BYTES)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    pngu_byte_if.sink            i_byte,
    pngu_cfg_if.sink             i_cfg,
    input  wire logic            i_full,
    output logic                 o_push,
    output pngu_pkg::t_task      o_task,
    output logic [COL_W-1:0]     o_col
);

    localparam int LEN_W = ($clog2(MAX_ROW_BYTES + 1) > pngu_pkg::ROW_LEN_W)
                         ? $clog2(MAX_ROW_BYTES + 1) : pngu_pkg::ROW_LEN_W;

    logic [pngu_pkg::ROW_LEN_W-1:0] r_row_length;
    logic [pngu_pkg::BPP_W-1:0]     r_bpp;
    logic [COL_W-1:0]               r_col,      n_col;
    logic                           r_expect,   n_expect;
    logic                           r_first,    n_first;
    logic                           r_halted,   n_halted;
    pngu_pkg::t_filter              r_filter,   n_filter;

    logic                           accept;
    logic                           fs;
    logic                           exp_eff;
    logic                           first_eff;
    logic [COL_W-1:0]               col_eff;
    logic [LEN_W-1:0]               len_ext;
    logic [LEN_W-1:0]               len_eff;
    logic [pngu_pkg::BPP_W-1:0]     bpp_eff;
    logic                           last;
    logic                           use_left;

    assign i_byte.ready = !i_full;
    assign i_cfg.ready  = 1'b1;
    assign accept       = i_byte.valid && i_byte.ready;
    assign fs           = i_byte.frame_start;

    // out-of-range register values are clamped
    always_comb begin
        len_ext = LEN_W'(r_row_length);
        if (r_row_length == '0) begin
            len_eff = LEN_W'(1);
        end else if (len_ext > LEN_W'(MAX_ROW_BYTES)) begin
            len_eff = LEN_W'(MAX_ROW_BYTES);
        end else begin
            len_eff = len_ext;
        end
        if (r_bpp == '0) begin
            bpp_eff = pngu_pkg::BPP_W'(1);
        end else if (r_bpp > pngu_pkg::BPP_W'(MAX_BPP)) begin
            bpp_eff = pngu_pkg::BPP_W'(MAX_BPP);
        end else begin
            bpp_eff = r_bpp;
        end
    end

    assign exp_eff   = fs || r_expect;
    assign first_eff = fs || r_first;
    assign col_eff   = fs ? '0 : r_col;
    assign last      = ((LEN_W + 1)'(col_eff) + (LEN_W + 1)'(1)) >= (LEN_W + 1)'(len_eff);
    assign use_left  = LEN_W'(col_eff) >= LEN_W'(bpp_eff);

    always_comb begin
        n_col    = r_col;
        n_expect = r_expect;
        n_first  = r_first;
        n_halted = r_halted;
        n_filter = r_filter;
        o_push   = 1'b0;

        o_task.data      = i_byte.stream_byte;
        o_task.err       = 1'b0;
        o_task.last      = last;
        o_task.first_row = first_eff;
        o_task.use_left  = use_left;
        o_task.hist_idx  = pngu_pkg::HIST_IDX_W'(bpp_eff - pngu_pkg::BPP_W'(1));
        o_task.filter    = r_filter;
        o_col            = col_eff;

        if (accept) begin
            if (fs) begin
                n_halted = 1'b0;
                n_first  = 1'b1;
                n_expect = 1'b1;
                n_col    = '0;
            end
            if (fs || !r_halted) begin
                if (exp_eff) begin
                    if (i_byte.stream_byte > pngu_pkg::FLT_MAX_CODE) begin
                        n_halted   = 1'b1;
                        o_push     = 1'b1;
                        o_task.err = 1'b1;
                    end else begin
                        n_filter = pngu_pkg::t_filter'(i_byte.stream_byte[2:0]);
                        n_expect = 1'b0;
                        n_col    = '0;
                    end
                end else begin
                    o_push = 1'b1;
                    if (last) begin
                        n_col    = '0;
                        n_expect = 1'b1;
                        n_first  = 1'b0;
                    end else begin
                        n_col = col_eff + COL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= pngu_pkg::ROW_LEN_W'(8);
            r_bpp        <= pngu_pkg::BPP_W'(1);
            r_col        <= '0;
            r_expect     <= 1'b1;
            r_first      <= 1'b1;
            r_halted     <= 1'b0;
            r_filter     <= pngu_pkg::FLT_NONE;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    pngu_pkg::CFG_ROW_LENGTH: begin
                        r_row_length <= i_cfg.data[pngu_pkg::ROW_LEN_W-1:0];
                    end
                    pngu_pkg::CFG_BYTES_PER_PIXEL: begin
                        r_bpp <= i_cfg.data[pngu_pkg::BPP_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            r_col    <= n_col;
            r_expect <= n_expect;
            r_first  <= n_first;
            r_halted <= n_halted;
            r_filter <= n_filter;
        end
    end

    // dropped bytes after a bad filter never reach the back end
    a_halt_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_halted && !fs) |-> !o_push)
        else $error("byte queued while halted");

    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_task.err) |=> r_halted)
        else $error("error result without halt");

endmodule

`default_nettype wire

// ===== sv/pngu_queue.sv =====
// ----------------------------------------------------------------------------
// pngu_queue
// Short FIFO between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module pngu_queue #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    output logic              o_valid,
    output logic [W-1:0]      o_data,
    input  wire logic         i_pop
);

    logic [W-1:0]                r_mem [pngu_pkg::QDEPTH];
    logic [pngu_pkg::QPTR_W-1:0] r_wptr;
    logic [pngu_pkg::QPTR_W-1:0] r_rptr;
    logic [pngu_pkg::QCNT_W-1:0] r_cnt;
    logic                        do_pop;

    assign o_full  = r_cnt == pngu_pkg::QCNT_W'(pngu_pkg::QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + pngu_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + pngu_pkg::QPTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + pngu_pkg::QCNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - pngu_pkg::QCNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

endmodule

`default_nettype wire

// ===== sv/pngu_back.sv =====
// ----------------------------------------------------------------------------
// pngu_back
// Reads the row above, applies the predictor, updates line store and output.
// ----------------------------------------------------------------------------
`default_nettype none

module pngu_back #(
    parameter int MAX_ROW_BYTES = pngu_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_BPP       = pngu_pkg::MAX_BPP_DEF,
    localparam int COL_W        = $clog2(MAX_ROW_BYTES)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  pngu_pkg::t_task      i_q_task,
    input  wire logic [COL_W-1:0] i_q_col,
    output logic                 o_q_pop,
    pngu_pix_if.source           o_pix
);

    localparam int HIST_W = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;

    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] p;
        logic signed [9:0] da;
        logic signed [9:0] db;
        logic signed [9:0] dc;
        logic [9:0]        pa;
        logic [9:0]        pb;
        logic [9:0]        pc;
        p  = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({2'b00, c});
        da = p - $signed({2'b00, a});
        db = p - $signed({2'b00, b});
        dc = p - $signed({2'b00, c});
        pa = da[9] ? 10'(-da) : 10'(da);
        pb = db[9] ? 10'(-db) : 10'(db);
        pc = dc[9] ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end
        return c;
    endfunction

    // stage 2: item waiting for its line-store read data
    logic                 r_s2_valid;
    pngu_pkg::t_task      r_s2_task;
    logic [COL_W-1:0]     r_s2_col;
    logic                 r_fwd;
    logic [7:0]           r_fwd_data;

    logic [7:0]           r_left   [MAX_BPP];
    logic [7:0]           r_upleft [MAX_BPP];

    logic                 r_o_valid;
    logic [7:0]           r_o_pix;
    logic                 r_o_last;
    logic                 r_o_bad;

    logic                 out_free;
    logic                 s2_fire;
    logic                 adv;
    logic                 ram_we;
    logic [7:0]           ram_rdata;
    logic [7:0]           above;
    logic [7:0]           a;
    logic [7:0]           b;
    logic [7:0]           c;
    logic [7:0]           pred;
    logic [7:0]           recon;
    logic [8:0]           ab_sum;
    logic [HIST_W-1:0]    hidx;

    assign out_free = !r_o_valid || o_pix.ready;
    assign s2_fire  = r_s2_valid && out_free;
    assign adv      = i_q_valid && (!r_s2_valid || s2_fire);
    assign o_q_pop  = adv;
    assign ram_we   = s2_fire && !r_s2_task.err;

    pngu_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s2_col),
        .i_wdata (recon),
        .i_re    (adv),
        .i_raddr (i_q_col),
        .o_rdata (ram_rdata)
    );

    assign hidx  = r_s2_task.hist_idx[HIST_W-1:0];
    assign above = r_fwd ? r_fwd_data : ram_rdata;
    assign b     = r_s2_task.first_row ? 8'd0 : above;
    assign a     = r_s2_task.use_left ? r_left[hidx]   : 8'd0;
    assign c     = r_s2_task.use_left ? r_upleft[hidx] : 8'd0;
    assign ab_sum = {1'b0, a} + {1'b0, b};

    always_comb begin
        case (r_s2_task.filter)
            pngu_pkg::FLT_SUB:     pred = a;
            pngu_pkg::FLT_UP:      pred = b;
            pngu_pkg::FLT_AVERAGE: pred = ab_sum[8:1];
            pngu_pkg::FLT_PAETH:   pred = paeth(a, b, c);
            default:               pred = 8'd0;
        endcase
    end

    assign recon = r_s2_task.data + pred;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_task  <= i_q_task;
            r_s2_col   <= i_q_col;
            // write this cycle to the same entry is not yet visible in the RAM
            r_fwd      <= ram_we && (r_s2_col == i_q_col);
            r_fwd_data <= recon;
        end
        if (ram_we) begin
            for (int i = 0; i < MAX_BPP; i++) begin
                r_left[i]   <= (i == 0) ? recon : r_left[(i == 0) ? 0 : i - 1];
                r_upleft[i] <= (i == 0) ? b     : r_upleft[(i == 0) ? 0 : i - 1];
            end
        end
        if (s2_fire) begin
            r_o_pix  <= r_s2_task.err ? 8'd0 : recon;
            r_o_last <= r_s2_task.err ? 1'b0 : r_s2_task.last;
            r_o_bad  <= r_s2_task.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (adv) begin
                r_s2_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_fire) begin
                r_o_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_pix.valid      = r_o_valid;
    assign o_pix.pixel_byte = r_o_pix;
    assign o_pix.row_last   = r_o_last;
    assign o_pix.bad_filter = r_o_bad;

    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !out_free) |=> (r_s2_valid && $stable(r_s2_col)))
        else $error("stage 2 item lost during stall");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_bad) |-> (r_o_pix == 8'd0 && !r_o_last))
        else $error("malformed error result");

    a_no_err_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_fire && r_s2_task.err) |=> (r_o_valid && r_o_bad))
        else $error("error item did not reach output");

endmodule

`default_nettype wire

// ===== sv/png_scanline_unfilter.sv =====
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG scanline filter reconstruction on an inflated byte stream.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle while the queue has room and
// returns one reconstructed byte per data byte, sustaining one transaction
// per clock on both sides unless the output stalls. A byte passes front-end
// classify into a two-entry queue, line-store read, then predictor into the
// output register. The rate is set by the single read port of the line store,
// read once per data byte. Good filter-type bytes and dropped bytes give no
// output. The line store has no clearing pass; it is written as each row is
// rebuilt, and the first row of a frame uses zero for the row above.
// Config writes are accepted at any time but must only be issued while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES = pngu_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_BPP       = pngu_pkg::MAX_BPP_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pngu_byte_if.sink   i_byte,
    pngu_cfg_if.sink    i_cfg,
    pngu_pix_if.source  o_pix
);

    localparam int COL_W = $clog2(MAX_ROW_BYTES);
    localparam int QW    = $bits(pngu_pkg::t_task) + COL_W;

    // front end -> queue
    logic                 push;
    logic                 full;
    pngu_pkg::t_task      f_task;
    logic [COL_W-1:0]     f_col;

    // queue -> back end
    logic                 q_valid;
    logic                 q_pop;
    logic [QW-1:0]        q_data;
    pngu_pkg::t_task      q_task;
    logic [COL_W-1:0]     q_col;

    // Front: config registers, row/column tracking, filter-type decode and
    // halt-after-error. Only data bytes and the error result are queued.
    pngu_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_BPP       (MAX_BPP)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_task  (f_task),
        .o_col   (f_col)
    );

    // Queue lets the front keep taking bytes while the output is stalled.
    pngu_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_task, f_col}),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    assign q_task = pngu_pkg::t_task'(q_data[QW-1:COL_W]);
    assign q_col  = q_data[COL_W-1:0];

    // Back: line-store read with write-to-read forwarding, left/upper-left
    // histories, predictor, output register.
    pngu_back #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_BPP       (MAX_BPP)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_task  (q_task),
        .i_q_col   (q_col),
        .o_q_pop   (q_pop),
        .o_pix     (o_pix)
    );

endmodule

`default_nettype wire
